[rtl/five_sample_olympic_adc_filter_macros.svh]
// Assertion macros for the five-sample olympic converter filter.
`ifndef FIVE_SAMPLE_OLYMPIC_ADC_FILTER_MACROS_SVH
`define FIVE_SAMPLE_OLYMPIC_ADC_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define OFIL_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("olympic filter check failed");

// Condition must never be true outside reset.
`define OFIL_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("olympic filter forbidden condition");

`else

`define OFIL_ASSERT(label, prop)
`define OFIL_NEVER(label, cond)

`endif

`endif

[rtl/ofil_pkg.sv]
// Shared constants and types for the olympic converter filter.
package ofil_pkg;

    localparam int CHANNELS = 5;
    localparam int SMP_W    = 12;
    localparam int CHAN_W   = 3;
    localparam int HIST     = 4;
    localparam int WIN_N    = HIST + 1;
    localparam int ROW_W    = HIST * SMP_W;
    localparam int WIN_W    = WIN_N * SMP_W;
    localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W    = 14;
    localparam int CNT_W    = 2;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;

    // Highest valid channel number, one bit wider than the channel field.
    localparam logic [CHAN_W:0] CHAN_LAST = (CHAN_W + 1)'(CHANNELS);

    // Reciprocal of three for sums below 2^16: floor(s / 3) = (s * R) >> 17.
    localparam int               RECIP_W      = 16;
    localparam logic [RECIP_W-1:0] RECIP3     = 16'd43691;
    localparam int               RECIP3_SHIFT = 17;

    // Sum and count of the samples kept by one window.
    typedef struct packed {
        logic             vld;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } t_stat;

endpackage

[rtl/ofil_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ofil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ofil_window.sv]
// Window statistics: extremes, then sum and count of the samples between them.
module ofil_window
    import ofil_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic             i_ok,
    input  logic [WIN_W-1:0] i_win,
    input  logic             i_take,
    output t_stat            o_stat
);

    logic             r_va;
    logic             r_oka;
    logic [WIN_W-1:0] r_win;
    logic [SMP_W-1:0] r_mx;
    logic [SMP_W-1:0] r_mn;
    logic [SMP_W-1:0] n_mx;
    logic [SMP_W-1:0] n_mn;
    t_stat            r_stat;
    logic [SUM_W-1:0] n_sum;
    logic [2:0]       n_cnt;

    // Maximum and minimum of the five window samples.
    always_comb begin
        logic [SMP_W-1:0] v;
        n_mx = i_win[SMP_W-1:0];
        n_mn = i_win[SMP_W-1:0];
        for (int k = 1; k < WIN_N; k++) begin
            v = i_win[k*SMP_W +: SMP_W];
            if (v > n_mx) begin
                n_mx = v;
            end
            if (v < n_mn) begin
                n_mn = v;
            end
        end
    end

    // Sum and count of the samples strictly between the extremes.
    always_comb begin
        logic [SMP_W-1:0] v;
        n_sum = '0;
        n_cnt = '0;
        for (int k = 0; k < WIN_N; k++) begin
            v = r_win[k*SMP_W +: SMP_W];
            if (r_oka && v > r_mn && v < r_mx) begin
                n_sum = n_sum + SUM_W'(v);
                n_cnt = n_cnt + 3'd1;
            end
        end
    end

    // Control of both stages; the second holds its result until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va       <= 1'b0;
            r_stat.vld <= 1'b0;
        end else begin
            r_va <= i_vld;
            if (r_va) begin
                r_stat.vld <= 1'b1;
            end else if (i_take) begin
                r_stat.vld <= 1'b0;
            end
        end
    end

    // Payload of both stages.
    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_win <= i_win;
            r_mx  <= n_mx;
            r_mn  <= n_mn;
            r_oka <= i_ok;
        end
        if (r_va) begin
            r_stat.sum <= n_sum;
            r_stat.cnt <= n_cnt[CNT_W-1:0];
        end
    end

    assign o_stat = r_stat;

endmodule

[rtl/ofil_div.sv]
// Floor division of the kept sum by a count of one to three.
module ofil_div
    import ofil_pkg::*;
(
    input  t_stat            i_stat,
    output logic [SMP_W-1:0] o_quot
);

    logic [SUM_W+RECIP_W-1:0] prod;

    // Division by three through a multiply by its reciprocal.
    assign prod = (SUM_W + RECIP_W)'(i_stat.sum) * (SUM_W + RECIP_W)'(RECIP3);

    always_comb begin
        case (i_stat.cnt)
            2'd1:    o_quot = i_stat.sum[SMP_W-1:0];
            2'd2:    o_quot = i_stat.sum[SMP_W:1];
            2'd3:    o_quot = prod[RECIP3_SHIFT +: SMP_W];
            default: o_quot = '0;
        endcase
    end

endmodule

[rtl/five_sample_olympic_adc_filter.sv]
// Top level of the five-sample olympic converter filter.
// Each request names a channel and a new 12-bit sample. The four previous samples of each
// channel are kept as one 48-bit row of a small RAM; a request reads its row, shifts the
// sample in, writes the row back and averages the samples strictly between the window's
// minimum and maximum (floor mean, 0 when none qualify, kept count alongside). Invalid
// channels give 0 and leave the history alone. One request is in work at a time: a
// request is accepted, then takes the RAM read cycle, the extremes stage and the sum
// stage before its result lands in the output register; a new request is accepted only
// once that result is taken in, and the output register lets the next request enter
// while a result waits. Histories read as zero after reset through one valid bit per
// channel row, so there is no clearing pass.
`include "five_sample_olympic_adc_filter_macros.svh"

module five_sample_olympic_adc_filter
    import ofil_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // [2:0] channel, [14:3] sample, [15] zero
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata    // [11:0] filtered, [13:12] kept_count, [15:14] zero
);

    logic [CHAN_W-1:0] chan;
    logic [SMP_W-1:0]  smp;
    logic [CHAN_W:0]   chan_m1;
    logic              chan_ok;
    logic              accept;
    logic              take;

    logic                r_busy;
    logic                r_v1;
    logic                r_ok1;
    logic [SMP_W-1:0]    r_smp1;
    logic [ADDR_W-1:0]   r_addr1;
    logic [CHANNELS-1:0] r_row_vld;

    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] new_row;
    logic [WIN_W-1:0] win;
    logic             wr_en;

    t_stat            stat;
    logic [SMP_W-1:0] quot;

    logic             r_m_valid;
    logic [SMP_W-1:0] r_filt;
    logic [CNT_W-1:0] r_kept;

    // Input unpacking and channel check.
    assign chan    = i_s_tdata[CHAN_W-1:0];
    assign smp     = i_s_tdata[CHAN_W +: SMP_W];
    assign chan_m1 = {1'b0, chan} - (CHAN_W + 1)'(1);
    assign chan_ok = (chan != '0) && ({1'b0, chan} <= CHAN_LAST);

    assign o_s_tready = !r_busy;
    assign accept     = i_s_tvalid && !r_busy;
    assign take       = stat.vld && (!r_m_valid || i_m_tready);

    // History rows, one per channel, oldest sample in the low bits.
    ofil_ram #(
        .WIDTH(ROW_W),
        .DEPTH(CHANNELS)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_addr1),
        .i_wdata(new_row),
        .i_re   (accept),
        .i_raddr(ADDR_W'(chan_m1)),
        .o_rdata(ram_rdata)
    );

    // Shift the new sample into the row and write it back.
    assign row     = r_row_vld[r_addr1] ? ram_rdata : '0;
    assign win     = {r_smp1, row};
    assign new_row = {r_smp1, row[ROW_W-1:SMP_W]};
    assign wr_en   = r_v1 && r_ok1;

    // Request control, row valid bits and output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_v1      <= 1'b0;
            r_row_vld <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_v1 <= accept;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (take) begin
                r_busy <= 1'b0;
            end
            if (wr_en) begin
                r_row_vld[r_addr1] <= 1'b1;
            end
            if (take) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Request payload and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok1   <= chan_ok;
            r_smp1  <= smp;
            r_addr1 <= ADDR_W'(chan_m1);
        end
        if (take) begin
            r_filt <= quot;
            r_kept <= stat.cnt;
        end
    end

    ofil_window u_window (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_v1),
        .i_ok   (r_ok1),
        .i_win  (win),
        .i_take (take),
        .o_stat (stat)
    );

    ofil_div u_div (
        .i_stat(stat),
        .o_quot(quot)
    );

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {(OUT_W - SMP_W - CNT_W)'(0), r_kept, r_filt};

    // Checks on the request flow and the result.
    `OFIL_ASSERT(a_busy_after_accept, accept |=> !o_s_tready)
    `OFIL_ASSERT(a_write_follows_accept, wr_en |-> $past(accept))
    `OFIL_NEVER(a_stat_while_ready, stat.vld && o_s_tready)
    `OFIL_ASSERT(a_zero_when_none_kept, (o_m_tvalid && r_kept == '0) |-> (r_filt == '0))

endmodule
